// ===== sv/frmz_pkg.sv =====
package frmz_pkg;

    localparam int DEFAULT_MAX_WIDTH  = 128;
    localparam int DEFAULT_MAX_HEIGHT = 128;

    localparam int COORD_W = 8;
    localparam int PIXEL_W = 24;
    localparam int DIM_W   = 8;
    localparam int MODE_W  = 2;
    localparam int CFG_ADDR_W = 2;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [DIM_W-1:0] RESET_WIDTH  = 8'd128;
    localparam logic [DIM_W-1:0] RESET_HEIGHT = 8'd128;

    localparam logic [CFG_ADDR_W-1:0] CFG_SRC_WIDTH      = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SRC_HEIGHT     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_TRANSFORM_MODE = 2'd2;

    localparam logic [MODE_W-1:0] MODE_MIRROR   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ROTATE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ZOOM_IN  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_ZOOM_OUT = 2'd3;

    localparam logic OPC_WRITE = 1'b0;
    localparam logic OPC_READ  = 1'b1;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_READ,
        OP_REJECT
    } op_kind_t;

    typedef struct packed {
        logic               opcode;
        logic [COORD_W-1:0] coord_x;
        logic [COORD_W-1:0] coord_y;
        logic [PIXEL_W-1:0] pixel_in;
    } in_item_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel_out;
        logic               out_of_range;
    } out_item_t;

    // classified operation passed from front to back
    typedef struct packed {
        op_kind_t           kind;
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        logic [PIXEL_W-1:0] pixel;
    } op_item_t;

endpackage

// ===== sv/frmz_front.sv =====
module frmz_front #(
    parameter int MAX_WIDTH  = frmz_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = frmz_pkg::DEFAULT_MAX_HEIGHT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [frmz_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [frmz_pkg::DIM_W-1:0]           cfg_data,
    input  logic                                 accept,
    input  frmz_pkg::in_item_t                   cmd,
    output frmz_pkg::op_item_t                   item
);
    import frmz_pkg::*;

    localparam logic [DIM_W-1:0] WIDTH_CAP  = DIM_W'((MAX_WIDTH  < 255) ? MAX_WIDTH  : 255);
    localparam logic [DIM_W-1:0] HEIGHT_CAP = DIM_W'((MAX_HEIGHT < 255) ? MAX_HEIGHT : 255);

    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic [MODE_W-1:0] mode_reg;

    logic [DIM_W-1:0]   w_eff;
    logic [DIM_W-1:0]   h_eff;
    logic [DIM_W:0]     out_w;
    logic [DIM_W:0]     out_h;
    logic               wr_ok;
    logic               rd_ok;
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RESET_WIDTH;
            height_reg <= RESET_HEIGHT;
            mode_reg   <= MODE_MIRROR;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_SRC_WIDTH:      width_reg  <= cfg_data;
                CFG_SRC_HEIGHT:     height_reg <= cfg_data;
                CFG_TRANSFORM_MODE: mode_reg   <= cfg_data[MODE_W-1:0];
                default:            ;
            endcase
        end
    end

    // clamp the frame size to the store
    assign w_eff = (width_reg  > WIDTH_CAP)  ? WIDTH_CAP  : width_reg;
    assign h_eff = (height_reg > HEIGHT_CAP) ? HEIGHT_CAP : height_reg;

    always_comb
    begin
        case (mode_reg)
            MODE_MIRROR:
            begin
                out_w = {1'b0, w_eff};
                out_h = {1'b0, h_eff};
                sx    = w_eff - 8'd1 - cmd.coord_x;
                sy    = cmd.coord_y;
            end
            MODE_ROTATE:
            begin
                out_w = {1'b0, h_eff};
                out_h = {1'b0, w_eff};
                sx    = cmd.coord_y;
                sy    = h_eff - 8'd1 - cmd.coord_x;
            end
            MODE_ZOOM_IN:
            begin
                out_w = {w_eff, 1'b0};
                out_h = {h_eff, 1'b0};
                sx    = {1'b0, cmd.coord_x[COORD_W-1:1]};
                sy    = {1'b0, cmd.coord_y[COORD_W-1:1]};
            end
            MODE_ZOOM_OUT:
            begin
                out_w = {2'b00, w_eff[DIM_W-1:1]};
                out_h = {2'b00, h_eff[DIM_W-1:1]};
                sx    = {cmd.coord_x[COORD_W-2:0], 1'b0};
                sy    = {cmd.coord_y[COORD_W-2:0], 1'b0};
            end
            default:
            begin
                out_w = '0;
                out_h = '0;
                sx    = '0;
                sy    = '0;
            end
        endcase
    end

    assign wr_ok = (cmd.coord_x < w_eff) && (cmd.coord_y < h_eff);
    assign rd_ok = ({1'b0, cmd.coord_x} < out_w) && ({1'b0, cmd.coord_y} < out_h);

    always_comb
    begin
        item.pixel = cmd.pixel_in;
        if (cmd.opcode == OPC_WRITE)
        begin
            item.kind = wr_ok ? OP_WRITE : OP_REJECT;
            item.sx   = cmd.coord_x;
            item.sy   = cmd.coord_y;
        end
        else
        begin
            item.kind = rd_ok ? OP_READ : OP_REJECT;
            item.sx   = sx;
            item.sy   = sy;
        end
    end

    property p_write_in_frame;
        @(posedge clk) disable iff (!rst_n)
        (accept && item.kind == OP_WRITE) |-> (item.sx < w_eff && item.sy < h_eff);
    endproperty
    a_write_in_frame: assert property (p_write_in_frame)
        else $error("write classified outside the source frame");

    property p_read_in_frame;
        @(posedge clk) disable iff (!rst_n)
        (accept && item.kind == OP_READ) |-> (item.sx < w_eff && item.sy < h_eff);
    endproperty
    a_read_in_frame: assert property (p_read_in_frame)
        else $error("read mapped outside the source frame");

endmodule

// ===== sv/frmz_fifo.sv =====
module frmz_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  frmz_pkg::op_item_t push_item,
    input  logic               pop,
    output logic               full,
    output logic               not_empty,
    output frmz_pkg::op_item_t head
);
    import frmz_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    op_item_t         slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

    property p_no_overflow;
        @(posedge clk) disable iff (!rst_n)
        !(push && full);
    endproperty
    a_no_overflow: assert property (p_no_overflow)
        else $error("transfer pushed into a full queue");

    property p_count_bound;
        @(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT;
    endproperty
    a_count_bound: assert property (p_count_bound)
        else $error("queue fill count beyond depth");

endmodule

// ===== sv/frmz_back.sv =====
module frmz_back #(
    parameter int MAX_WIDTH  = frmz_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = frmz_pkg::DEFAULT_MAX_HEIGHT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  frmz_pkg::op_item_t  item,
    output logic                done,
    output frmz_pkg::out_item_t result
);
    import frmz_pkg::*;

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(MAX_WIDTH);

    logic [PIXEL_W-1:0] frame_mem [DEPTH];
    logic [PIXEL_W-1:0] rd_data_reg;
    logic               done_reg;
    logic               oor_reg;
    logic               done_next;
    logic               oor_next;
    logic [ADDR_W-1:0]  addr;
    logic               mem_we;
    logic               mem_re;

    // row-major address, row stride of the full store width
    assign addr   = ADDR_W'(ADDR_W'(item.sy) * ROW_STRIDE + ADDR_W'(item.sx));
    assign mem_we = item_valid && (item.kind == OP_WRITE);
    assign mem_re = item_valid && (item.kind == OP_READ);

    always_comb
    begin
        done_next = 1'b0;
        oor_next  = 1'b0;
        if (item_valid)
        begin
            case (item.kind)
                OP_WRITE:  done_next = 1'b0;
                OP_READ:   done_next = 1'b1;
                OP_REJECT:
                begin
                    done_next = 1'b1;
                    oor_next  = 1'b1;
                end
                default:   done_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            frame_mem[addr] <= item.pixel;
        if (mem_re)
            rd_data_reg <= frame_mem[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            oor_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
            oor_reg  <= oor_next;
        end
    end

    assign done              = done_reg;
    assign result.out_of_range = oor_reg;
    assign result.pixel_out  = oor_reg ? '0 : rd_data_reg;

    property p_done_follows_item;
        @(posedge clk) disable iff (!rst_n)
        done |-> $past(item_valid && item.kind != OP_WRITE);
    endproperty
    a_done_follows_item: assert property (p_done_follows_item)
        else $error("result strobe without a read or rejected transfer");

    property p_no_write_result;
        @(posedge clk) disable iff (!rst_n)
        mem_we |=> !done;
    endproperty
    a_no_write_result: assert property (p_no_write_result)
        else $error("stored write produced a result");

endmodule

// ===== sv/frame_mirror_rotate_zoom.sv =====
// Frame store with mirror, rotate-90 and 2x zoom read-out.
//
// Command channel: an item transfers on a rising edge with start high and
// busy low. A write item (opcode 0) stores pixel_in at source (coord_x,
// coord_y); a read item (opcode 1) names an output coordinate and returns
// the pixel that transform_mode places there.
// Result channel: done is high for one cycle with the result; there is no
// back-pressure. In-range writes give no result; out-of-range writes and
// all reads give exactly one, with out_of_range set and pixel zero when
// the coordinate lies outside the frame for the active mode.
// Path: a transferred command is registered in the two-entry queue, and
// its result and pixel are registered again with the store read.
// Throughput: one item per cycle; the back end drains the queue every
// cycle, so busy only rises if the queue fills, which it does not here.
// Configuration: cfg_addr 0 source width, 1 source height, 2 mode; other
// indices are ignored. cfg_ready is always high. Write only while idle.
// Reset clears the queue and strobe and restores 128 x 128, mirror mode;
// the pixel store is not cleared and must be written before it is read.
module frame_mirror_rotate_zoom #(
    parameter int MAX_WIDTH  = frmz_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = frmz_pkg::DEFAULT_MAX_HEIGHT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [frmz_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [frmz_pkg::DIM_W-1:0]      cfg_data,
    input  logic                            start,
    output logic                            busy,
    input  frmz_pkg::in_item_t              cmd,
    output logic                            done,
    output frmz_pkg::out_item_t             result
);
    import frmz_pkg::*;

    logic     accept;
    logic     q_full;
    logic     q_valid;
    op_item_t front_item;
    op_item_t q_head;

    assign cfg_ready = 1'b1;
    assign busy      = q_full;
    assign accept    = start && !q_full;

    frmz_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .accept   (accept),
        .cmd      (cmd),
        .item     (front_item)
    );

    frmz_fifo u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_item (front_item),
        .pop       (q_valid),
        .full      (q_full),
        .not_empty (q_valid),
        .head      (q_head)
    );

    frmz_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (q_valid),
        .item       (q_head),
        .done       (done),
        .result     (result)
    );

endmodule
